### sv/wos_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the odometry block.
package wos_pkg;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CNT_W       = 5;
    localparam int MUL_BITS    = 28;
    localparam int DIV_W       = 28;
    localparam int Z_W         = 26;
    localparam int XY_W        = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [MUL_BITS-1:0] DEG_SCALE = 28'd240315917;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [26:0] QUARTER_Z = 27'sd5898240;
    localparam logic signed [26:0] HALF_Z    = 27'sd11796480;

    localparam logic [15:0] MM_PER_TICK_RST = 16'd9559;
    localparam logic [9:0]  TRACK_RST       = 10'd200;
    localparam logic [13:0] SLIP_THR_RST    = 14'd128;

    typedef enum logic [1:0] {
        ST_DISABLED = 2'd0,
        ST_ARMED    = 2'd1,
        ST_SLIP     = 2'd2,
        ST_UPDATED  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 4'd0,
        REG_MM_TICK   = 4'd1,
        REG_TRACK     = 4'd2,
        REG_SLIP_THR  = 4'd3
    } t_reg_idx;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [21:0] atan_val(input logic [CNT_W-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/wos_ifs.sv
// Handshake interfaces for samples, results and configuration writes.
interface wos_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
    logic signed [15:0] gyro_heading;
    modport source (output valid, left_ticks, right_ticks, gyro_heading, input ready);
    modport sink   (input valid, left_ticks, right_ticks, gyro_heading, output ready);
endinterface

interface wos_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [14:0] odom_heading;
    logic signed [31:0] total_distance;
    logic signed [24:0] forward_step;
    modport source (output valid, status, pos_x, pos_y, odom_heading, total_distance,
                    forward_step, input ready);
    modport sink   (input valid, status, pos_x, pos_y, odom_heading, total_distance,
                    forward_step, output ready);
endinterface

interface wos_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/wos_cordic.sv
// One CORDIC rotation per cycle while i_en is high, on registered x, y and residual angle.
module wos_cordic
    import wos_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic                   i_en,
    input  logic [CNT_W-1:0]       i_idx,
    input  logic signed [Z_W-1:0]  i_z0,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y
);
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic signed [XY_W-1:0] w_xs, w_ys;
    logic signed [Z_W-1:0]  w_at;

    assign w_xs = r_x >>> i_idx;
    assign w_ys = r_y >>> i_idx;
    assign w_at = $signed({{(Z_W-22){1'b0}}, atan_val(i_idx)});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= i_z0;
        end else if (i_en) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule

### sv/wos_div.sv
// Restoring divider, one quotient bit per cycle.
module wos_div
    import wos_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [9:0]       i_den,
    output logic [DIV_W-1:0] o_quot,
    output logic             o_done
);
    logic [DIV_W-1:0] r_num;
    logic [9:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [10:0]      w_rem2;
    logic             w_ge;

    assign w_rem2 = {r_rem, r_num[DIV_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? 10'(w_rem2 - {1'b0, i_den}) : w_rem2[9:0];
            r_num <= {r_num[DIV_W-2:0], w_ge};
        end
    end

    assign o_quot = r_num;
    assign o_done = (r_cnt == '0);
endmodule

### sv/wheel_odometry_slip_check_top.sv
// Top level: wheel odometry with gyro slip check and CORDIC position update.
// Sequence from sample transaction to result: prepare, bit-serial turn multiply
// with the CORDIC alongside, bit-serial divide by the track width, finish.
// A new sample is taken only in idle, once the previous one has finished, so
// the serial multiply and divide set the rate; a stalled result adds its wait.
// Reset: synchronous active-low clears pose, heading, distance and arming,
// and loads the register defaults; no clearing pass is needed.
module wheel_odometry_slip_check_top
    import wos_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wos_smp_if.sink     i_smp,
    wos_res_if.source   o_res,
    wos_cfg_if.sink     i_cfg
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;

    // Configuration registers. Writes must be issued only in idle; the block does not check.
    logic        r_enable;
    logic [15:0] r_k;
    logic [9:0]  r_tw;
    logic [13:0] r_thr;

    // Architectural state.
    logic               r_armed;
    logic signed [31:0] r_x_acc, r_y_acc, r_dist;
    logic signed [14:0] r_odom;
    logic signed [15:0] r_prev_gyro;

    // Per-sample working registers.
    logic signed [15:0] r_left, r_right, r_gyro;
    logic signed [24:0] r_step;
    logic [59:0]        r_mcand, r_acc;
    logic               r_neg, r_flip;
    logic [16:0]        r_dimu_abs;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [56:0] r_prod;
    logic signed [31:0] r_dx, r_dy;

    // Result register.
    logic               r_out_valid;
    t_status            r_status;
    logic signed [24:0] r_out_step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_k      <= MM_PER_TICK_RST;
            r_tw     <= TRACK_RST;
            r_thr    <= SLIP_THR_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_ENABLE:   r_enable <= i_cfg.data[0];
                REG_MM_TICK:  r_k      <= i_cfg.data;
                REG_TRACK:    r_tw     <= i_cfg.data[9:0];
                REG_SLIP_THR: r_thr    <= i_cfg.data[13:0];
                default: ;
            endcase
        end
    end

    // Prepare-stage arithmetic: ticks are negated, then summed and differenced.
    logic signed [16:0] w_l, w_r;
    logic signed [17:0] w_sum, w_diff;
    logic signed [34:0] w_pstep, w_pturn, w_step_rnd, w_pturn_abs;
    logic signed [16:0] w_g, w_gh, w_dimu;
    logic signed [26:0] w_z, w_zf;
    logic               w_flip;

    always_comb begin
        w_l      = -$signed({r_left[15], r_left});
        w_r      = -$signed({r_right[15], r_right});
        w_sum    = 18'(w_l) + 18'(w_r);
        w_diff   = 18'(w_r) - 18'(w_l);
        w_pstep  = w_sum * $signed({1'b0, r_k});
        w_pturn  = w_diff * $signed({1'b0, r_k});
        w_step_rnd  = (w_pstep + 35'sd4096) >>> 13;
        w_pturn_abs = w_pturn[34] ? -w_pturn : w_pturn;
        w_g    = {r_gyro[15], r_gyro};
        w_dimu = w_g - $signed({r_prev_gyro[15], r_prev_gyro});
        // The heading used for position is folded once into +-180 degrees.
        if (w_g > 17'sd11520)       w_gh = w_g - 17'sd23040;
        else if (w_g < -17'sd11520) w_gh = w_g + 17'sd23040;
        else                        w_gh = w_g;
        w_z = $signed({w_gh, 10'b0});
        // Beyond +-90 degrees the CORDIC works on the opposite angle and the
        // result is negated.
        if (w_z > QUARTER_Z) begin
            w_zf = w_z - HALF_Z;  w_flip = 1'b1;
        end else if (w_z < -QUARTER_Z) begin
            w_zf = w_z + HALF_Z;  w_flip = 1'b1;
        end else begin
            w_zf = w_z;           w_flip = 1'b0;
        end
    end

    // CORDIC steps during the multiply state while the multiply count is below CORDIC_STEPS.
    logic signed [XY_W-1:0] w_cx, w_cy;
    logic                   w_cor_en;
    assign w_cor_en = (r_state == S_MUL) && (32'(r_cnt) < CORDIC_STEPS);

    wos_cordic u_cordic (
        .i_clk  (i_clk),
        .i_load (r_state == S_PREP),
        .i_en   (w_cor_en),
        .i_idx  (r_cnt),
        .i_z0   (w_zf[Z_W-1:0]),
        .o_x    (w_cx),
        .o_y    (w_cy)
    );

    // Rounded quotient of the turn: floor((mag + tw*2^31) / 2^32) / tw.
    logic [9:0]       w_tw_eff;
    logic [60:0]      w_rnd_sum;
    logic             w_div_start, w_div_done;
    logic [DIV_W-1:0] w_quot;

    assign w_tw_eff    = (r_tw == '0) ? 10'd1 : r_tw;
    assign w_rnd_sum   = {1'b0, r_acc} + (61'(w_tw_eff) << 31);
    assign w_div_start = (r_state == S_DIV) && (r_cnt == '0);

    wos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_rnd_sum[59:32]),
        .i_den   (w_tw_eff),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // Finish-stage logic: slip test and heading update.
    logic signed [29:0] w_turn, w_slip_diff, w_h, w_hw;
    logic               w_slip, w_fin_go;

    always_comb begin
        w_turn      = r_neg ? -$signed({2'b0, w_quot}) : $signed({2'b0, w_quot});
        w_slip_diff = $signed({2'b0, w_quot}) - $signed({13'b0, r_dimu_abs});
        w_slip      = w_slip_diff > $signed({16'b0, r_thr});
        w_h         = 30'(r_odom) + w_turn;
        if (w_h < -30'sd11520)     w_hw = w_h + 30'sd23040;
        else if (w_h > 30'sd11520) w_hw = w_h - 30'sd23040;
        else                       w_hw = w_h;
        if (w_hw > 30'sd11520)       w_hw = 30'sd11520;
        else if (w_hw < -30'sd11520) w_hw = -30'sd11520;
    end

    assign w_fin_go    = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
    assign i_smp.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_smp.valid) r_state <= S_PREP;
                S_PREP: begin
                    r_state <= S_MUL;
                    r_cnt   <= '0;
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(MUL_BITS - 1)) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0 && w_div_done) r_state <= S_FIN;
                    if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                end
                S_FIN: if (w_fin_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers that carry no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_smp.valid) begin
            r_left  <= i_smp.left_ticks;
            r_right <= i_smp.right_ticks;
            r_gyro  <= i_smp.gyro_heading;
        end
        if (r_state == S_PREP) begin
            r_step     <= w_step_rnd[24:0];
            r_mcand    <= {28'b0, w_pturn_abs[31:0]};
            r_acc      <= '0;
            r_neg      <= w_pturn[34];
            r_flip     <= w_flip;
            r_dimu_abs <= w_dimu[16] ? 17'(-w_dimu) : 17'(w_dimu);
        end
        // Bit-serial multiply by 11520/pi in Q16, one constant bit per cycle.
        if (r_state == S_MUL) begin
            if (DEG_SCALE[r_cnt]) r_acc <= r_acc + r_mcand;
            r_mcand <= {r_mcand[58:0], 1'b0};
        end
        // Position deltas share one multiplier over the divider's cycles.
        if (r_state == S_DIV) begin
            if (r_cnt == 5'd1) begin
                r_prod <= r_step * (r_flip ? -w_cx : w_cx);
            end else if (r_cnt == 5'd2) begin
                r_dx   <= 32'((r_prod + 57'sd536870912) >>> 30);
                r_prod <= r_step * (r_flip ? -w_cy : w_cy);
            end else if (r_cnt == 5'd3) begin
                r_dy   <= 32'((r_prod + 57'sd536870912) >>> 30);
            end
        end
    end

    // Architectural state update and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_dist      <= '0;
            r_odom      <= '0;
            r_prev_gyro <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_DISABLED;
            r_out_step  <= '0;
        end else begin
            if (r_out_valid && o_res.ready) r_out_valid <= 1'b0;
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
                r_out_step  <= '0;
                if (!r_enable) begin
                    r_status <= ST_DISABLED;
                end else if (!r_armed) begin
                    r_armed  <= 1'b1;
                    r_status <= ST_ARMED;
                end else begin
                    r_prev_gyro <= r_gyro;
                    r_out_step  <= r_step;
                    if (w_slip) begin
                        r_status <= ST_SLIP;
                    end else begin
                        r_status <= ST_UPDATED;
                        r_odom   <= w_hw[14:0];
                        r_dist   <= r_dist + 32'(r_step);
                        r_x_acc  <= r_x_acc + r_dx;
                        r_y_acc  <= r_y_acc + r_dy;
                    end
                end
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.pos_x          = r_x_acc;
    assign o_res.pos_y          = r_y_acc;
    assign o_res.odom_heading   = r_odom;
    assign o_res.total_distance = r_dist;
    assign o_res.forward_step   = r_out_step;
endmodule

### sv/wos_checker.sv
// Port-level assertions for the odometry block and the bind that attaches them.
module wos_checker
    import wos_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [24:0] i_out_step,
    input logic [31:0] i_out_x
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x) &&
            $stable(i_out_status))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while a sample is in work");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_nostep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_DISABLED || i_out_status == ST_ARMED)
            |-> i_out_step == '0)
        else $error("forward step reported without a measured sample");
endmodule

bind wheel_odometry_slip_check_top wos_checker u_wos_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_step   (o_res.forward_step),
    .i_out_x      (o_res.pos_x)
);
